// ===== hdl/gfau_pkg.sv =====
// shared types, constants and helpers for the gf(2^m) arithmetic unit
`default_nettype none

package gfau_pkg;

  localparam int unsigned MaxDegree = 16;
  localparam int unsigned ElemW     = MaxDegree;
  localparam int unsigned PolyW     = MaxDegree + 1;
  localparam int unsigned DegW      = 5;
  localparam int unsigned MulSteps  = PolyW;
  localparam int unsigned MulCntW   = $clog2(MulSteps + 1);
  localparam int unsigned PowCntW   = 4;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [DegW-1:0]  DegReset  = DegW'(8);
  localparam logic [PolyW-1:0] PolyReset = PolyW'(285);
  localparam logic [DegW-1:0]  DegMin    = DegW'(2);
  localparam logic [DegW-1:0]  DegMax    = DegW'(MaxDegree);

  // register index as decoded from paddr[2]
  localparam logic RegDegree  = 1'b0;
  localparam logic RegModulus = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_POW = 2'd2,
    CMD_INV = 2'd3
  } cmd_e;

  // field setup seen by the serial multiplier
  typedef struct packed {
    logic [DegW-1:0]  deg;
    logic [PolyW-1:0] poly;
  } field_t;

  // request into the serial multiplier
  typedef struct packed {
    logic             start;
    logic [ElemW-1:0] mcand;
    logic [PolyW-1:0] mplier;
  } mul_req_t;

  // degree of a nonzero polynomial (zero reads as degree 0)
  function automatic logic [DegW-1:0] poly_deg(input logic [PolyW-1:0] x);
    logic [DegW-1:0] d;
    d = '0;
    for (int i = 0; i < PolyW; i++) begin
      if (x[i]) begin
        d = DegW'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gfau_mul.sv =====
// bit-serial msb-first multiplier with interleaved modular reduction
`default_nettype none

module gfau_mul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gfau_pkg::field_t         field_i,
  input  wire gfau_pkg::mul_req_t       req_i,
  output logic                          done_o,
  output logic [gfau_pkg::ElemW-1:0]    prod_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [gfau_pkg::MulCntW-1:0]   cnt_q, cnt_d;
  logic [gfau_pkg::ElemW-1:0]     acc_q, acc_d;
  logic [gfau_pkg::ElemW-1:0]     mc_q, mc_d;
  logic [gfau_pkg::PolyW-1:0]     sh_q, sh_d;
  logic [gfau_pkg::PolyW-1:0]     step;

  always_comb begin
    // shift, add the multiplicand on a one bit, fold back the x^m term
    step = {acc_q, 1'b0} ^ (sh_q[gfau_pkg::PolyW-1] ? {1'b0, mc_q} : '0);
    if (step[field_i.deg]) begin
      step = step ^ field_i.poly;
    end

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = gfau_pkg::MulCntW'(gfau_pkg::MulSteps);
      acc_d  = '0;
      mc_d   = req_i.mcand;
      sh_d   = req_i.mplier;
    end else if (busy_q) begin
      acc_d = step[gfau_pkg::ElemW-1:0];
      sh_d  = {sh_q[gfau_pkg::PolyW-2:0], 1'b0};
      cnt_d = cnt_q - gfau_pkg::MulCntW'(1);
      if (cnt_q == gfau_pkg::MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== hdl/gf2m_arithmetic_unit.sv =====
// top level of the gf(2^m) arithmetic unit: apb registers, command sequencer, euclid inverter
`default_nettype none

// per command: operand a is reduced first; add and multiply then reduce operand b, power
//   runs 16 squarings plus up to 16 multiplies on the serial multiplier, and inverse runs
//   one euclid step per cycle before reducing its cofactor
// one command in flight at a time; busy_o stays high until the cycle of the done strobe
// done_o is high for one cycle; the result holds until the next; the receiver cannot stall
// reset is asynchronous, active low: idle, field degree 8, modulus 0x11d
module gf2m_arithmetic_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command transfer
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [1:0]                      cmd_i,
  input  wire logic [gfau_pkg::ElemW-1:0]      operand_a_i,
  input  wire logic [gfau_pkg::ElemW-1:0]      operand_b_i,
  input  wire logic [15:0]                     exponent_i,
  // result strobe
  output logic                                 done_o,
  output logic [gfau_pkg::ElemW-1:0]           field_result_o,
  output logic                                 no_inverse_o,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gfau_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [gfau_pkg::ApbDataW-1:0]   pwdata,
  output logic [gfau_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RED_A   = 8'b0000_0010,
    ST_RED_B   = 8'b0000_0100,
    ST_MUL     = 8'b0000_1000,
    ST_POW_SQ  = 8'b0001_0000,
    ST_POW_MUL = 8'b0010_0000,
    ST_INV     = 8'b0100_0000,
    ST_INV_RED = 8'b1000_0000
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [gfau_pkg::DegW-1:0]  deg_q;
  logic [gfau_pkg::PolyW-1:0] poly_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q  <= gfau_pkg::DegReset;
      poly_q <= gfau_pkg::PolyReset;
    end else if (wr_en) begin
      if (paddr[2] == gfau_pkg::RegDegree) begin
        deg_q <= pwdata[gfau_pkg::DegW-1:0];
      end else begin
        poly_q <= pwdata[gfau_pkg::PolyW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == gfau_pkg::RegModulus) begin
      prdata = {{(gfau_pkg::ApbDataW - gfau_pkg::PolyW){1'b0}}, poly_q};
    end else begin
      prdata = {{(gfau_pkg::ApbDataW - gfau_pkg::DegW){1'b0}}, deg_q};
    end
  end

  // effective degree clamped to the supported range, implied x^m term forced on
  gfau_pkg::field_t           field;
  logic [gfau_pkg::DegW-1:0]  m_eff;
  logic [gfau_pkg::PolyW-1:0] low_mask;

  always_comb begin
    if (deg_q < gfau_pkg::DegMin) begin
      m_eff = gfau_pkg::DegMin;
    end else if (deg_q > gfau_pkg::DegMax) begin
      m_eff = gfau_pkg::DegMax;
    end else begin
      m_eff = deg_q;
    end
    low_mask   = (gfau_pkg::PolyW'(1) << m_eff) - gfau_pkg::PolyW'(1);
    field.deg  = m_eff;
    field.poly = (poly_q & low_mask) | (gfau_pkg::PolyW'(1) << m_eff);
  end

  // ---------------------------------------------------------------------------
  // shared serial multiplier: also reduces raw operands (multiplicand 1)
  // ---------------------------------------------------------------------------
  gfau_pkg::mul_req_t         mreq;
  logic                       mul_done;
  logic [gfau_pkg::ElemW-1:0] mul_prod;

  gfau_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .field_i (field),
    .req_i   (mreq),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  state_e                       state_q, state_d;
  gfau_pkg::cmd_e               cmd_q, cmd_d;
  logic [gfau_pkg::ElemW-1:0]   a_q, a_d;
  logic [gfau_pkg::ElemW-1:0]   b_q, b_d;
  logic [gfau_pkg::ElemW-1:0]   opb_q, opb_d;
  logic [15:0]                  exp_q, exp_d;
  logic [gfau_pkg::PowCntW-1:0] pcnt_q, pcnt_d;
  logic [gfau_pkg::ElemW-1:0]   acc_q, acc_d;
  // euclid remainders and cofactors
  logic [gfau_pkg::PolyW-1:0]   r0_q, r0_d, r1_q, r1_d;
  logic [gfau_pkg::PolyW-1:0]   s0_q, s0_d, s1_q, s1_d;
  logic [gfau_pkg::DegW-1:0]    d0, d1, kshift;

  logic                         fin;
  logic [gfau_pkg::ElemW-1:0]   fin_res;
  logic                         fin_err;
  logic                         done_q;
  logic [gfau_pkg::ElemW-1:0]   res_q;
  logic                         err_q;

  assign d0     = gfau_pkg::poly_deg(r0_q);
  assign d1     = gfau_pkg::poly_deg(r1_q);
  assign kshift = d0 - d1;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    a_d     = a_q;
    b_d     = b_q;
    opb_d   = opb_q;
    exp_d   = exp_q;
    pcnt_d  = pcnt_q;
    acc_d   = acc_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    mreq    = '0;
    fin     = 1'b0;
    fin_res = '0;
    fin_err = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d       = gfau_pkg::cmd_e'(cmd_i);
          opb_d       = operand_b_i;
          exp_d       = exponent_i;
          // reduce operand a first, whatever the command
          mreq.start  = 1'b1;
          mreq.mcand  = gfau_pkg::ElemW'(1);
          mreq.mplier = {1'b0, operand_a_i};
          state_d     = ST_RED_A;
        end
      end

      ST_RED_A: begin
        if (mul_done) begin
          a_d = mul_prod;
          unique case (cmd_q)
            gfau_pkg::CMD_ADD, gfau_pkg::CMD_MUL: begin
              mreq.start  = 1'b1;
              mreq.mcand  = gfau_pkg::ElemW'(1);
              mreq.mplier = {1'b0, opb_q};
              state_d     = ST_RED_B;
            end
            gfau_pkg::CMD_POW: begin
              // square-and-multiply over 16 exponent bits, msb first; 1 squared is 1
              pcnt_d      = '1;
              mreq.start  = 1'b1;
              mreq.mcand  = gfau_pkg::ElemW'(1);
              mreq.mplier = gfau_pkg::PolyW'(1);
              state_d     = ST_POW_SQ;
            end
            gfau_pkg::CMD_INV: begin
              if (mul_prod == '0) begin
                fin     = 1'b1;
                fin_err = 1'b1;
                state_d = ST_IDLE;
              end else begin
                r0_d    = field.poly;
                r1_d    = {1'b0, mul_prod};
                s0_d    = '0;
                s1_d    = gfau_pkg::PolyW'(1);
                state_d = ST_INV;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_RED_B: begin
        if (mul_done) begin
          b_d = mul_prod;
          if (cmd_q == gfau_pkg::CMD_ADD) begin
            fin     = 1'b1;
            fin_res = a_q ^ mul_prod;
            state_d = ST_IDLE;
          end else begin
            mreq.start  = 1'b1;
            mreq.mcand  = a_q;
            mreq.mplier = {1'b0, mul_prod};
            state_d     = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          fin     = 1'b1;
          fin_res = mul_prod;
          state_d = ST_IDLE;
        end
      end

      ST_POW_SQ, ST_POW_MUL: begin
        if (mul_done) begin
          acc_d = mul_prod;
          if (state_q == ST_POW_SQ && exp_q[15]) begin
            mreq.start  = 1'b1;
            mreq.mcand  = a_q;
            mreq.mplier = {1'b0, mul_prod};
            state_d     = ST_POW_MUL;
          end else if (pcnt_q == '0) begin
            fin     = 1'b1;
            fin_res = mul_prod;
            state_d = ST_IDLE;
          end else begin
            exp_d       = {exp_q[14:0], 1'b0};
            pcnt_d      = pcnt_q - gfau_pkg::PowCntW'(1);
            mreq.start  = 1'b1;
            mreq.mcand  = mul_prod;
            mreq.mplier = {1'b0, mul_prod};
            state_d     = ST_POW_SQ;
          end
        end
      end

      ST_INV: begin
        // one euclid step a cycle: cancel the leading term of r0, or swap
        if (r1_q == '0) begin
          if (r0_q == gfau_pkg::PolyW'(1)) begin
            mreq.start  = 1'b1;
            mreq.mcand  = gfau_pkg::ElemW'(1);
            mreq.mplier = s0_q;
            state_d     = ST_INV_RED;
          end else begin
            fin     = 1'b1;
            fin_err = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (r0_q != '0 && d0 >= d1) begin
          r0_d = r0_q ^ (r1_q << kshift);
          s0_d = s0_q ^ (s1_q << kshift);
        end else begin
          r0_d = r1_q;
          r1_d = r0_q;
          s0_d = s1_q;
          s1_d = s0_q;
        end
      end

      ST_INV_RED: begin
        if (mul_done) begin
          fin     = 1'b1;
          fin_res = mul_prod;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    opb_q  <= opb_d;
    exp_q  <= exp_d;
    pcnt_q <= pcnt_d;
    acc_q  <= acc_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    if (fin) begin
      res_q <= fin_res;
      err_q <= fin_err;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign field_result_o = res_q;
  assign no_inverse_o   = err_q;

endmodule

`default_nettype wire

// ===== bench/tb_gf2m_arithmetic_unit.sv =====
// self-checking testbench for the gf(2^m) arithmetic unit: directed table, then random commands
module tb_gf2m_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gfau_pkg::*;

  // register addresses, one 32-bit word per register
  localparam logic [ApbAddrW-1:0] AddrDegree  = {RegDegree, 2'b00};
  localparam logic [ApbAddrW-1:0] AddrModulus = {RegModulus, 2'b00};

  // random part: fixed field settings first, then fully random register values
  localparam int NumFixedPhases = 11;
  localparam int NumPhases      = 14;
  localparam int ItemsPerPhase  = 72;
  localparam int NumDirected    = 26;
  // drain margin after the last result, about one power command
  localparam int TailCycles     = 600;

  // ---------------------------------------------------------------------------
  // dut signals, all inputs driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  logic [1:0]          cmd_i       = '0;
  logic [ElemW-1:0]    operand_a_i = '0;
  logic [ElemW-1:0]    operand_b_i = '0;
  logic [15:0]         exponent_i  = '0;
  logic                done_o;
  logic [ElemW-1:0]    field_result_o;
  logic                no_inverse_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  gf2m_arithmetic_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .exponent_i     (exponent_i),
    .done_o         (done_o),
    .field_result_o (field_result_o),
    .no_inverse_o   (no_inverse_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  typedef struct {
    cmd_e        op;
    logic [15:0] res;
    logic        err;
  } field_result_t;

  // one entry per accepted command, oldest first
  field_result_t pending_results[$];

  // our copy of the field setup, changed only while the block is idle
  logic [4:0]  field_deg_q  = DegReset;
  logic [16:0] field_poly_q = PolyReset;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned field_settings  = 1;
  int unsigned op_count [4]    = '{default: 0};

  // ---------------------------------------------------------------------------
  // field arithmetic predictor, vectors kept 64 bits wide so products never clip
  // ---------------------------------------------------------------------------

  // degree register clamped into the supported range
  function automatic int active_degree(input logic [4:0] d);
    if (d < DegMin) return int'(DegMin);
    if (d > DegMax) return int'(DegMax);
    return int'(d);
  endfunction

  // x^m always implied, modulus bits at or above m dropped
  function automatic logic [63:0] field_poly(input int m, input logic [16:0] p);
    logic [63:0] low_mask;
    low_mask = (64'd1 << m) - 64'd1;
    return (64'(p) & low_mask) | (64'd1 << m);
  endfunction

  // index of the highest set bit, -1 for the zero polynomial
  function automatic int top_bit(input logic [63:0] x);
    int d;
    d = -1;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) d = i;
    end
    return d;
  endfunction

  function automatic logic [63:0] mod_reduce(input logic [63:0] x, input logic [63:0] f,
                                             input int m);
    for (int i = 63; i >= m; i--) begin
      if (x[i]) x ^= f << (i - m);
    end
    return x;
  endfunction

  // carry-less product of two reduced elements, then reduced
  function automatic logic [63:0] field_mul(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] f, input int m);
    logic [63:0] prod;
    prod = '0;
    for (int i = 0; i < m; i++) begin
      if (b[i]) prod ^= a << i;
    end
    return mod_reduce(prod, f, m);
  endfunction

  // left-to-right square and multiply over all 16 exponent bits
  function automatic logic [63:0] field_pow(input logic [63:0] base, input logic [15:0] e,
                                            input logic [63:0] f, input int m);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 15; i >= 0; i--) begin
      acc = field_mul(acc, acc, f, m);
      if (e[i]) acc = field_mul(acc, base, f, m);
    end
    return acc;
  endfunction

  // extended euclid over gf(2)[x]; fails when the gcd with the modulus is not 1
  function automatic bit field_inverse(input logic [63:0] a, input logic [63:0] f,
                                       input int m, output logic [63:0] inv);
    logic [63:0] r0, r1, s0, s1, t;
    int          d0, d1;
    r0 = f;
    s0 = '0;
    r1 = a;
    s1 = 64'd1;
    while (r1 != '0) begin
      d1 = top_bit(r1);
      d0 = top_bit(r0);
      while (d0 >= d1) begin
        r0 ^= r1 << (d0 - d1);
        s0 ^= s1 << (d0 - d1);
        d0 = top_bit(r0);
      end
      t = r0; r0 = r1; r1 = t;
      t = s0; s0 = s1; s1 = t;
    end
    if (r0 != 64'd1) begin
      inv = '0;
      return 1'b0;
    end
    inv = mod_reduce(s0, f, m);
    return 1'b1;
  endfunction

  // expected result of one command under the current field setup
  function automatic void predict_result(input cmd_e op, input logic [15:0] a_in,
                                         input logic [15:0] b_in, input logic [15:0] e_in,
                                         output logic [15:0] res, output logic err);
    int          m;
    logic [63:0] f, a, b, r;
    m   = active_degree(field_deg_q);
    f   = field_poly(m, field_poly_q);
    // operands above x^m get folded back in for every command
    a   = mod_reduce(64'(a_in), f, m);
    b   = mod_reduce(64'(b_in), f, m);
    r   = '0;
    err = 1'b0;
    case (op)
      CMD_ADD: r = a ^ b;
      CMD_MUL: r = field_mul(a, b, f, m);
      CMD_POW: r = field_pow(a, e_in, f, m);
      default: begin
        // zero, or an element sharing a factor with a reducible modulus
        if (a == '0 || !field_inverse(a, f, m, r)) begin
          r   = '0;
          err = 1'b1;
        end
      end
    endcase
    res = r[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  // setup phase, access phase until pready, then an idle phase so psel never toggles in one step
  task automatic apb_transfer(input logic wr, input logic [ApbAddrW-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // both registers must read back as our copy
  task automatic check_fields();
    logic [31:0] rd;
    apb_transfer(1'b0, AddrDegree, '0, rd);
    if (rd[4:0] !== field_deg_q) begin
      $display("%0t ns: field_degree readback expected %0d got %0d", $time, field_deg_q,
               rd[4:0]);
      mismatches++;
    end
    apb_transfer(1'b0, AddrModulus, '0, rd);
    if (rd[16:0] !== field_poly_q) begin
      $display("%0t ns: modulus_poly readback expected %h got %h", $time, field_poly_q,
               rd[16:0]);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // hold start low until every outstanding result has come back
  task automatic drain_pause();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // reprogram the field only with nothing in flight; upper pwdata bits are junk
  task automatic program_field(input logic [4:0] deg, input logic [16:0] poly);
    logic [31:0] rd;
    drain_pause();
    apb_transfer(1'b1, AddrDegree, {27'($urandom), deg}, rd);
    apb_transfer(1'b1, AddrModulus, {15'($urandom), poly}, rd);
    field_deg_q  = deg;
    field_poly_q = poly;
    field_settings++;
    check_fields();
  endtask

  // present one command and wait for its transfer; start stays high on return
  task automatic issue_cmd(input cmd_e op, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] e, input logic known,
                           input logic [15:0] known_res, input logic known_err);
    field_result_t want;
    start_i     <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    exponent_i  <= e;
    do @(posedge clk_i); while (busy_o);
    want.op = op;
    if (known) begin
      want.res = known_res;
      want.err = known_err;
    end else begin
      predict_result(op, a, b, e, want.res, want.err);
    end
    pending_results.push_back(want);
    op_count[op]++;
  endtask

  // sender gaps of random length in roughly 38 of 100 slots
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // element biased toward zero, one, all ones, with some unreduced operands
  function automatic logic [15:0] pick_operand(input int m);
    logic [15:0] mask;
    mask = 16'((32'd1 << m) - 32'd1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return mask;
      2:       return 16'd1;
      3:       return 16'($urandom);
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: reset field x^8+x^4+x^3+x^2+1 unless a row reprograms it
  // columns: reprogram, degree, modulus, op, a, b, exponent, known, result, no_inverse
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        reconfig;
    logic [4:0]  deg;
    logic [16:0] poly;
    cmd_e        op;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] e;
    logic        known;
    logic [15:0] res;
    logic        err;
  } directed_step_t;

  directed_step_t directed_steps [NumDirected] = '{
    // add, unused exponent carries junk
    '{1'b0, 5'd0, 17'h0, CMD_ADD, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_ADD, 16'h00ff, 16'h00ff, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_ADD, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_ADD, 16'haaaa, 16'h5555, 16'h1234, 1'b0, 16'h0000, 1'b0},
    // multiply: zero operands, identity, x^7 * x wraps to the modulus tail
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'h0000, 16'hffff, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'h00ff, 16'h0000, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'h0001, 16'h00ff, 16'h0000, 1'b1, 16'h00ff, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'h0080, 16'h0002, 16'h0000, 1'b1, 16'h001d, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'hffff, 16'hffff, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // power: exponent zero even for base zero, group order 255, max exponent
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h0000, 16'hffff, 16'h0000, 1'b1, 16'h0001, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h00ff, 16'h0000, 16'h0000, 1'b1, 16'h0001, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h0000, 16'h0000, 16'h0005, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h0053, 16'h0000, 16'h00ff, 1'b1, 16'h0001, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h0001, 16'h0000, 16'hffff, 1'b1, 16'h0001, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_POW, 16'h0002, 16'h0000, 16'hffff, 1'b0, 16'h0000, 1'b0},
    // inverse: zero has none, one is its own, unreduced operands
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'h0000, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b1},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h0001, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'h0100, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // modulus x^8 is reducible: x shares a factor, x+1 does not
    '{1'b1, 5'd8, 17'h00100, CMD_INV, 16'h0002, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'h0003, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // degree 0 clamps to 2, modulus bits above x^2 ignored
    '{1'b1, 5'd0, 17'h1ffff, CMD_MUL, 16'hffff, 16'h0003, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
    // degree 31 clamps to 16
    '{1'b1, 5'd31, 17'h1002d, CMD_POW, 16'hffff, 16'h0000, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_MUL, 16'hffff, 16'hffff, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 5'd0, 17'h0, CMD_INV, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  // field settings for the random part; the last two take degree out of range
  logic [4:0] phase_deg [NumFixedPhases] = '{
    5'd2, 5'd3, 5'd4, 5'd7, 5'd8, 5'd8, 5'd9, 5'd13, 5'd16, 5'd1, 5'd20
  };
  logic [16:0] phase_poly [NumFixedPhases] = '{
    17'h00007, 17'h0000b, 17'h00013, 17'h00083, 17'h0011b,
    17'h001ff,  // reducible degree-8 modulus
    17'd577, 17'h0201b, 17'h1100b, 17'h1ffff, 17'h1002d
  };

  // ---------------------------------------------------------------------------
  // result checker: the receiver cannot stall, so every strobe is a transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing outstanding: field_result %h no_inverse %b",
                 $time, field_result_o, no_inverse_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (field_result_o !== want.res) begin
          $display("%0t ns: %s field_result expected %h got %h", $time, want.op.name(),
                   want.res, field_result_o);
          mismatches++;
        end
        if (no_inverse_o !== want.err) begin
          $display("%0t ns: %s no_inverse expected %b got %b", $time, want.op.name(),
                   want.err, no_inverse_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cmd_e        op;
    logic [15:0] a_val, b_val, e_val;
    int          m;
    int          item_no;
    item_no = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // registers must come out of reset at degree 8, modulus 0x11d
    check_fields();

    foreach (directed_steps[i]) begin
      if (directed_steps[i].reconfig) begin
        program_field(directed_steps[i].deg, directed_steps[i].poly);
      end
      issue_cmd(directed_steps[i].op, directed_steps[i].a, directed_steps[i].b,
                directed_steps[i].e, directed_steps[i].known, directed_steps[i].res,
                directed_steps[i].err);
      maybe_idle(1'b1);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < NumFixedPhases) begin
        program_field(phase_deg[ph], phase_poly[ph]);
      end else begin
        program_field(5'($urandom), 17'($urandom));
      end
      m = active_degree(field_deg_q);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // now and then let the block run completely dry mid-phase
        if (k == ItemsPerPhase / 2 && ph % 3 == 1) begin
          drain_pause();
        end
        op    = cmd_e'($urandom_range(3));
        a_val = pick_operand(m);
        b_val = pick_operand(m);
        case ($urandom_range(7))
          0:       e_val = 16'($urandom_range(3));
          1:       e_val = 16'hffff;
          default: e_val = 16'($urandom);
        endcase
        issue_cmd(op, a_val, b_val, e_val, 1'b0, '0, 1'b0);
        item_no++;
        // back-to-back stretch with no sender gaps at all
        maybe_idle(item_no < 300 || item_no >= 500);
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // catch any stray strobe after the last result
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d commands (add %0d, mul %0d, pow %0d, inv %0d) over %0d field setups",
             op_count[CMD_ADD] + op_count[CMD_MUL] + op_count[CMD_POW] + op_count[CMD_INV],
             op_count[CMD_ADD], op_count[CMD_MUL], op_count[CMD_POW], op_count[CMD_INV],
             field_settings);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_gf2m_arithmetic_unit: done, clean");
    end else begin
      $display("tb_gf2m_arithmetic_unit: done, errors");
    end
    $finish;
  end

  // hang guard: several times the all-power run with the longest sender gaps
  initial begin : watchdog
    #35_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_gf2m_arithmetic_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gfau_pkg.sv
hdl/gfau_mul.sv
hdl/gf2m_arithmetic_unit.sv
bench/tb_gf2m_arithmetic_unit.sv
